>>> hdl/edf_task_scheduler_assert.svh
// ----------------------------------------------------------------------------
// edf_task_scheduler_assert
// Concurrent assertion macros shared by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef EDF_TASK_SCHEDULER_ASSERT_SVH
`define EDF_TASK_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define EDF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define EDF_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define EDF_ASSERT(lbl, clk, rstn, prop, msg)
`define EDF_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> hdl/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and codes of the EDF task scheduler.
// ----------------------------------------------------------------------------
package edf_pkg;
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_ADD_RT   = 3'd1;
  localparam logic [2:0] CMD_ADD_PL   = 3'd2;
  localparam logic [2:0] CMD_SELECT   = 3'd3;
  localparam logic [2:0] CMD_PREEMPT  = 3'd4;
  // Unused command codes; they only report an accept.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam logic [2:0] ST_RT_SEL   = 3'd0;
  localparam logic [2:0] ST_PL_SEL   = 3'd1;
  localparam logic [2:0] ST_WAIT     = 3'd2;
  localparam logic [2:0] ST_NONE     = 3'd3;
  localparam logic [2:0] ST_ACCEPT   = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_TICKED   = 3'd6;

  // Command transfer payload.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  task_id;
    logic [31:0] start_time;
    logic [31:0] rel_deadline;
  } sched_cmd_t;

  // Result transfer payload.
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  chosen_id;
    logic [15:0] missed_total;
    logic        timeslice_on;
  } sched_res_t;

  // One real-time table entry.
  typedef struct packed {
    logic [31:0] release_ms;
    logic [31:0] dl_ms;
    logic [7:0]  ident;
  } rt_entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic        ins;     // sorted insert of new_entry
    logic        rem;     // remove at rem_idx position
    logic [8:0]  rem_idx;
    rt_entry_t   new_entry;
  } cell_ctl_t;
endpackage

>>> hdl/edf_stream_if.sv
// ----------------------------------------------------------------------------
// edf_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface edf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/edf_cell.sv
// ----------------------------------------------------------------------------
// edf_cell
// One slot of the sorted real-time table; trades entries with its neighbors.
// ----------------------------------------------------------------------------
module edf_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned MY_IDX = 0
) (
  input  logic               clk_i,
  input  edf_pkg::cell_ctl_t ctl_i,
  input  logic [IDX_W:0]     used_i,
  input  edf_pkg::rt_entry_t left_i,
  input  logic               left_gt_i,
  input  edf_pkg::rt_entry_t right_i,
  output edf_pkg::rt_entry_t entry_o,
  output logic               gt_o
);
  edf_pkg::rt_entry_t entry_q, entry_d;
  logic [IDX_W:0] my_pos;

  assign my_pos = (IDX_W + 1)'(MY_IDX);
  assign entry_o = entry_q;
  // This cell holds a live entry whose deadline exceeds the new one.
  assign gt_o = (my_pos < used_i) && (entry_q.dl_ms > ctl_i.new_entry.dl_ms);

  // Insert, remove or hold.
  always_comb begin
    entry_d = entry_q;
    priority if (ctl_i.ins) begin
      if (gt_o) begin
        entry_d = left_gt_i ? left_i : ctl_i.new_entry;
      end else if (my_pos == used_i) begin
        entry_d = left_gt_i ? left_i : ctl_i.new_entry;
      end
    end else if (ctl_i.rem) begin
      if (my_pos >= ctl_i.rem_idx[IDX_W:0]) entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end
endmodule

>>> hdl/edf_task_scheduler.sv
// ----------------------------------------------------------------------------
// edf_task_scheduler
// Earliest-deadline-first scheduler with a round-robin plain task queue.
// ----------------------------------------------------------------------------
// Usage: commands enter on cmd_if (valid/ready); every command gives one
// result on res_if. The real-time table is a chain of cells kept sorted by
// absolute deadline; an insert or remove acts on all cells at once.
// A select walks the chain one cell a cycle looking for the first released
// task, up to RT_SLOTS cells. One command is in flight at a time; the next
// is taken once the result register is free, so a stalled receiver holds
// the result and blocks further transfers. Reset empties both queues,
// zeroes the clock and the miss count; table contents need no clearing.
// ----------------------------------------------------------------------------
`include "edf_task_scheduler_assert.svh"
module edf_task_scheduler #(
  parameter int unsigned RT_SLOTS = 16,
  parameter int unsigned PLAIN_SLOTS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  edf_stream_if.sink   cmd_if,
  edf_stream_if.source res_if
);
  localparam int unsigned RW = $clog2(RT_SLOTS);
  localparam int unsigned PW = $clog2(PLAIN_SLOTS);
  localparam logic [RW:0] RT_FULL = (RW+1)'(RT_SLOTS);
  localparam logic [PW:0] PL_FULL = (PW+1)'(PLAIN_SLOTS);
  localparam logic [PW-1:0] PL_LAST = PW'(PLAIN_SLOTS - 1);
  localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_OUT = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [2:0]  cmd_q;
  logic [7:0]  tid_q;
  logic [31:0] start_q, rel_q;
  logic [31:0] now_q, now_d;
  logic [RW:0] used_q, used_d;
  logic [PW:0] pused_q, pused_d;
  logic [PW-1:0] phead_q, phead_d;
  logic        prun_v_q, prun_v_d, rrun_v_q, rrun_v_d, slice_q, slice_d;
  logic [7:0]  prun_id_q, prun_id_d;
  logic [31:0] rrun_dl_q, rrun_dl_d;
  logic [15:0] miss_q, miss_d;
  logic [RW:0] scan_q, scan_d;
  logic [2:0]  st_q, st_d;
  logic [7:0]  id_q, id_d;
  logic        rvalid_q, rvalid_d;

  // Plain FIFO storage (fifo index fixed by signal: small register file).
  logic [7:0] fifo_q [PLAIN_SLOTS];
  logic       fifo_we;
  logic [7:0] fifo_wdata;

  edf_pkg::cell_ctl_t ctl;
  edf_pkg::rt_entry_t ent [RT_SLOTS];
  logic gt [RT_SLOTS];
  edf_pkg::rt_entry_t scan_ent;
  logic [32:0] dl_sum;
  logic accept;
  logic hit;
  logic [PW:0] tail_sum;
  logic [PW-1:0] tail;
  logic [PW-1:0] phead_inc;

  assign dl_sum = {1'b0, start_q} + {1'b0, rel_q};

  // Cell chain.
  for (genvar g = 0; g < RT_SLOTS; g++) begin : g_cell
    edf_pkg::rt_entry_t lft, rgt;
    logic lgt;
    if (g == 0) begin : g_first
      assign lft = '0;
      assign lgt = 1'b0;
    end else begin : g_mid
      assign lft = ent[g-1];
      assign lgt = gt[g-1];
    end
    if (g == RT_SLOTS - 1) begin : g_last
      assign rgt = ent[g];
    end else begin : g_nr
      assign rgt = ent[g+1];
    end
    edf_cell #(.IDX_W(RW), .MY_IDX(g)) u_cell (
      .clk_i, .ctl_i(ctl), .used_i(used_q),
      .left_i(lft), .left_gt_i(lgt), .right_i(rgt),
      .entry_o(ent[g]), .gt_o(gt[g])
    );
  end

  assign scan_ent = ent[scan_q[RW-1:0]];

  assign cmd_if.ready = (state_q == S_IDLE) && !rvalid_q;
  assign accept = cmd_if.valid && cmd_if.ready;
  assign res_if.valid = rvalid_q;
  assign res_if.data.status = st_q;
  assign res_if.data.chosen_id = id_q;
  assign res_if.data.missed_total = miss_q;
  assign res_if.data.timeslice_on = slice_q;

  assign hit = (scan_ent.release_ms <= now_q);

  // Wrap the FIFO pointers at PLAIN_SLOTS.
  assign tail_sum = {1'b0, phead_q} + pused_q;
  assign tail = (tail_sum >= PL_FULL) ? PW'(tail_sum - PL_FULL) : PW'(tail_sum);
  assign phead_inc = (phead_q == PL_LAST) ? '0 : phead_q + 1'b1;

  // Cell control.
  always_comb begin
    ctl = '0;
    ctl.new_entry.release_ms = start_q;
    ctl.new_entry.dl_ms = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
    ctl.new_entry.ident = tid_q;
    ctl.rem_idx = 9'(scan_q);
    if (state_q == S_SCAN && cmd_q == edf_pkg::CMD_ADD_RT && used_q < RT_FULL)
      ctl.ins = 1'b1;
    if (state_q == S_SCAN && cmd_q == edf_pkg::CMD_SELECT && scan_q < used_q && hit)
      ctl.rem = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_SCAN;
      S_SCAN: if (cmd_q != edf_pkg::CMD_SELECT || used_q == '0 || scan_q >= used_q || hit)
                state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Execute the held command and build its result.
  always_comb begin
    now_d = now_q; used_d = used_q; pused_d = pused_q; phead_d = phead_q;
    prun_v_d = prun_v_q; rrun_v_d = rrun_v_q; slice_d = slice_q;
    prun_id_d = prun_id_q; rrun_dl_d = rrun_dl_q; miss_d = miss_q;
    scan_d = scan_q; st_d = st_q; id_d = id_q; rvalid_d = rvalid_q;
    fifo_we = 1'b0;
    fifo_wdata = tid_q;
    if (res_if.valid && res_if.ready) rvalid_d = 1'b0;
    if (accept) scan_d = '0;
    if (state_q == S_SCAN) begin
      id_d = '0;
      if (state_d == S_OUT) rvalid_d = 1'b1;
      unique case (cmd_q)
        edf_pkg::CMD_TICK: begin
          now_d = now_q + 32'd1; st_d = edf_pkg::ST_TICKED;
        end
        edf_pkg::CMD_ADD_RT: begin
          if (used_q >= RT_FULL) st_d = edf_pkg::ST_FULL;
          else begin used_d = used_q + 1'b1; st_d = edf_pkg::ST_ACCEPT; end
        end
        edf_pkg::CMD_ADD_PL: begin
          if (pused_q >= PL_FULL) st_d = edf_pkg::ST_FULL;
          else begin
            fifo_we = 1'b1; fifo_wdata = tid_q; pused_d = pused_q + 1'b1;
            st_d = edf_pkg::ST_ACCEPT;
          end
        end
        edf_pkg::CMD_SELECT: begin
          if (scan_q == '0) begin
            if (rrun_v_q && rrun_dl_q < now_q && miss_q != 16'hFFFF)
              miss_d = miss_q + 16'd1;
            rrun_v_d = 1'b0; prun_v_d = 1'b0;
          end
          if (used_q != '0) begin
            slice_d = 1'b0;
            if (scan_q >= used_q) st_d = edf_pkg::ST_WAIT;
            else if (hit) begin
              st_d = edf_pkg::ST_RT_SEL; id_d = scan_ent.ident;
              rrun_v_d = 1'b1; rrun_dl_d = scan_ent.dl_ms;
              used_d = used_q - 1'b1;
            end else scan_d = scan_q + 1'b1;
          end else begin
            slice_d = 1'b1;
            if (pused_q == '0) st_d = edf_pkg::ST_NONE;
            else begin
              st_d = edf_pkg::ST_PL_SEL; id_d = fifo_q[phead_q];
              prun_id_d = fifo_q[phead_q]; prun_v_d = 1'b1;
              phead_d = phead_inc; pused_d = pused_q - 1'b1;
            end
          end
        end
        edf_pkg::CMD_PREEMPT: begin
          if (prun_v_q && pused_q >= PL_FULL) begin
            st_d = edf_pkg::ST_PL_SEL; id_d = prun_id_q;
          end else if (prun_v_q) begin
            // Rotate: push running, pop head (head stays valid when empty).
            if (pused_q == '0) begin
              st_d = edf_pkg::ST_PL_SEL; id_d = prun_id_q;
            end else begin
              fifo_we = 1'b1; fifo_wdata = prun_id_q;
              st_d = edf_pkg::ST_PL_SEL; id_d = fifo_q[phead_q];
              prun_id_d = fifo_q[phead_q]; phead_d = phead_inc;
            end
          end else if (pused_q == '0) begin
            st_d = edf_pkg::ST_NONE;
          end else begin
            st_d = edf_pkg::ST_PL_SEL; id_d = fifo_q[phead_q];
            prun_id_d = fifo_q[phead_q]; prun_v_d = 1'b1;
            phead_d = phead_inc; pused_d = pused_q - 1'b1;
          end
        end
        default: st_d = edf_pkg::ST_ACCEPT;
      endcase
    end
  end

  // Capture the command on transfer.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_if.data.cmd;
      tid_q <= cmd_if.data.task_id;
      start_q <= cmd_if.data.start_time;
      rel_q <= cmd_if.data.rel_deadline;
    end
  end

  // Write the plain FIFO at its tail.
  always_ff @(posedge clk_i) begin
    if (fifo_we) fifo_q[tail] <= fifo_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      now_q <= '0; used_q <= '0; pused_q <= '0; phead_q <= '0;
      prun_v_q <= 1'b0; rrun_v_q <= 1'b0; slice_q <= 1'b0;
      prun_id_q <= '0; rrun_dl_q <= '0; miss_q <= '0;
      scan_q <= '0; st_q <= edf_pkg::ST_ACCEPT; id_q <= '0; rvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      now_q <= now_d; used_q <= used_d; pused_q <= pused_d; phead_q <= phead_d;
      prun_v_q <= prun_v_d; rrun_v_q <= rrun_v_d; slice_q <= slice_d;
      prun_id_q <= prun_id_d; rrun_dl_q <= rrun_dl_d; miss_q <= miss_d;
      scan_q <= scan_d; st_q <= st_d; id_q <= id_d; rvalid_q <= rvalid_d;
    end
  end

  `EDF_ASSERT(a_used_max, clk_i, rst_ni, used_q <= RT_FULL, "rt table overflow")
  `EDF_ASSERT(a_pused_max, clk_i, rst_ni, pused_q <= PL_FULL, "fifo overflow")
  `EDF_ASSERT_NEVER(a_busy_ready, clk_i, rst_ni, cmd_if.ready && rvalid_q, "ready while busy")
  `EDF_ASSERT(a_miss_mono, clk_i, rst_ni, miss_q >= $past(miss_q), "miss count fell")
endmodule
